// File: rtl/whc_pkg.sv
// whc_pkg: shared types, constants and the CRC-16/MODBUS byte update for the
// wire header checker. Depends on nothing; every rtl file imports it.
package whc_pkg;

  // Header geometry
  localparam int HEADER_BYTES = 24;
  localparam int STORED_BYTES = HEADER_BYTES - 2;
  localparam int IDX_W        = $clog2(HEADER_BYTES);

  // CRC-16/MODBUS: reflected polynomial, all-ones init, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // APB register map, word index = paddr[4:2]
  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_MAGIC_FIRST  = 3'd0,
    REG_MAGIC_SECOND = 3'd1,
    REG_EXP_VERSION  = 3'd2,
    REG_INVALID_TYPE = 3'd3,
    REG_MIN_LENGTH   = 3'd4
  } cfg_reg_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_CRC_ERR = 2'd2
  } status_e;

  // Configuration register contents
  typedef struct packed {
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [7:0] expected_version;
    logic [7:0] invalid_type_code;
    logic [7:0] min_header_length;
  } cfg_t;

  // One decoded header
  typedef struct packed {
    status_e     status;
    logic [7:0]  version;
    logic [7:0]  header_length;
    logic [7:0]  packet_kind;
    logic [7:0]  flag_bits;
    logic [7:0]  hop_limit;
    logic [7:0]  service_class;
    logic [15:0] source_node;
    logic [15:0] target_node;
    logic [31:0] connection_number;
    logic [31:0] sequence_number;
    logic [15:0] payload_length;
  } hdr_result_t;

  // Parser status seen by the top level
  typedef struct packed {
    logic s1_valid;
    logic result_fire;
  } parse_status_t;

  // One byte through the reflected CRC, bit at a time
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// File: rtl/whc_cfg_regs.sv
// whc_cfg_regs: APB configuration registers of the wire header checker.
// Depends on whc_pkg for the register map and the cfg_t struct.
module whc_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [whc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output whc_pkg::cfg_t          cfg_o
);
  import whc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  cfg_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cfg_reg_e'(paddr[4:2]);

  // Register write decode; unmapped words are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MAGIC_FIRST:  cfg_d.magic_first       = pwdata[7:0];
        REG_MAGIC_SECOND: cfg_d.magic_second      = pwdata[7:0];
        REG_EXP_VERSION:  cfg_d.expected_version  = pwdata[7:0];
        REG_INVALID_TYPE: cfg_d.invalid_type_code = pwdata[7:0];
        REG_MIN_LENGTH:   cfg_d.min_header_length = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_first       <= 8'd0;
      cfg_q.magic_second      <= 8'd0;
      cfg_q.expected_version  <= 8'd1;
      cfg_q.invalid_type_code <= 8'd0;
      cfg_q.min_header_length <= 8'd24;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    prdata = 32'd0;
    unique case (reg_sel)
      REG_MAGIC_FIRST:  prdata = {24'd0, cfg_q.magic_first};
      REG_MAGIC_SECOND: prdata = {24'd0, cfg_q.magic_second};
      REG_EXP_VERSION:  prdata = {24'd0, cfg_q.expected_version};
      REG_INVALID_TYPE: prdata = {24'd0, cfg_q.invalid_type_code};
      REG_MIN_LENGTH:   prdata = {24'd0, cfg_q.min_header_length};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/whc_parser.sv
// whc_parser: input word register, byte counter, running CRC, header store
// and the decode/check of a complete header. Depends on whc_pkg.
module whc_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   start_mark_i,
  input  whc_pkg::cfg_t          cfg_i,
  input  logic                   out_free_i,
  output whc_pkg::hdr_result_t   result_o,
  output whc_pkg::parse_status_t status_o
);
  import whc_pkg::*;

  // Input word register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;

  // Parse state
  logic             in_header_q, in_header_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       store_q [STORED_BYTES];
  logic [7:0]       rx_lo_q;

  logic             accept, advance, active, last, in_body;
  logic [IDX_W-1:0] idx_eff;
  logic [15:0]      crc_base, crc_new, rx_crc;
  logic [7:0]       crc_byte;
  logic             magic_bad, crc_bad, field_bad;
  logic [15:0]      src_node, dst_node;

  // Effective position of the word in the input register
  assign active   = s1_start_q | in_header_q;
  assign idx_eff  = s1_start_q ? '0 : idx_q;
  assign crc_base = s1_start_q ? CRC_INIT : crc_q;
  assign in_body  = idx_eff < IDX_W'(STORED_BYTES);
  assign last     = active && (idx_eff == IDX_W'(HEADER_BYTES - 1));
  assign crc_byte = in_body ? s1_byte_q : 8'h00;
  assign crc_new  = crc16_update(crc_base, crc_byte);

  // Handshake: a word that completes a header needs the output slot
  assign advance    = s1_valid_q && (!last || out_free_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_valid_d = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= start_mark_i;
    end
  end

  // Next parse state
  always_comb begin
    in_header_d = in_header_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    if (advance && active) begin
      if (last) begin
        in_header_d = 1'b0;
        idx_d       = '0;
        crc_d       = CRC_INIT;
      end else begin
        in_header_d = 1'b1;
        idx_d       = idx_eff + IDX_W'(1);
        crc_d       = crc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q <= 1'b0;
      idx_q       <= '0;
      crc_q       <= CRC_INIT;
    end else begin
      in_header_q <= in_header_d;
      idx_q       <= idx_d;
      crc_q       <= crc_d;
    end
  end

  // Header store and low CRC byte, written at the current position
  always_ff @(posedge clk_i) begin
    if (advance && active) begin
      for (int k = 0; k < STORED_BYTES; k++) begin
        if (idx_eff == IDX_W'(k)) begin
          store_q[k] <= s1_byte_q;
        end
      end
      if (idx_eff == IDX_W'(STORED_BYTES)) begin
        rx_lo_q <= s1_byte_q;
      end
    end
  end

  // Checks on a complete header
  assign rx_crc    = {s1_byte_q, rx_lo_q};
  assign src_node  = {store_q[9], store_q[8]};
  assign dst_node  = {store_q[11], store_q[10]};
  assign magic_bad = (store_q[0] != cfg_i.magic_first) ||
                     (store_q[1] != cfg_i.magic_second);
  assign crc_bad   = rx_crc != crc_new;
  assign field_bad = (store_q[2] != cfg_i.expected_version) ||
                     (store_q[3] < cfg_i.min_header_length) ||
                     (store_q[4] == cfg_i.invalid_type_code) ||
                     (src_node == 16'd0) || (dst_node == 16'd0);

  // Result: fields zero on magic or CRC failure
  always_comb begin
    result_o = '0;
    if (magic_bad) begin
      result_o.status = ST_INVALID;
    end else if (crc_bad) begin
      result_o.status = ST_CRC_ERR;
    end else begin
      result_o.status            = field_bad ? ST_INVALID : ST_OK;
      result_o.version           = store_q[2];
      result_o.header_length     = store_q[3];
      result_o.packet_kind       = store_q[4];
      result_o.flag_bits         = store_q[5];
      result_o.hop_limit         = store_q[6];
      result_o.service_class     = store_q[7];
      result_o.source_node       = src_node;
      result_o.target_node       = dst_node;
      result_o.connection_number = {store_q[15], store_q[14], store_q[13], store_q[12]};
      result_o.sequence_number   = {store_q[19], store_q[18], store_q[17], store_q[16]};
      result_o.payload_length    = {store_q[21], store_q[20]};
    end
  end

  assign status_o.s1_valid    = s1_valid_q;
  assign status_o.result_fire = advance && last;

endmodule

// File: rtl/whc_out_reg.sv
// whc_out_reg: result register that holds one decoded header word until the
// consumer takes it. Depends on whc_pkg for hdr_result_t.
module whc_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  whc_pkg::hdr_result_t result_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output whc_pkg::hdr_result_t result_o
);
  import whc_pkg::*;

  logic        valid_q, valid_d;
  hdr_result_t res_q;

  // Slot is free when empty or emptied this cycle
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

// File: rtl/wire_header_checker.sv
// wire_header_checker: fixed 24-byte header parser with CRC-16/MODBUS check.
// Throughput: one byte word per cycle, set by the one-byte CRC update, except
// that the byte that completes a header waits while the output slot is full. The 24th
// byte enters the input word register, and its result then enters the result register.
// Reset: async active low; control state and registers to defaults, parser
// idle waiting for a start mark, header store contents left as they are.
module wire_header_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [whc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        start_mark_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [7:0]                  version_o,
  output logic [7:0]                  header_length_o,
  output logic [7:0]                  packet_kind_o,
  output logic [7:0]                  flag_bits_o,
  output logic [7:0]                  hop_limit_o,
  output logic [7:0]                  service_class_o,
  output logic [15:0]                 source_node_o,
  output logic [15:0]                 target_node_o,
  output logic [31:0]                 connection_number_o,
  output logic [31:0]                 sequence_number_o,
  output logic [15:0]                 payload_length_o
);
  import whc_pkg::*;

  cfg_t          cfg;
  hdr_result_t   parse_res, out_res;
  parse_status_t pstat;
  logic          out_free;

  whc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  whc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .start_mark_i (start_mark_i),
    .cfg_i        (cfg),
    .out_free_i   (out_free),
    .result_o     (parse_res),
    .status_o     (pstat)
  );

  whc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (pstat.result_fire),
    .result_i    (parse_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  // Result fields to ports
  assign status_o            = out_res.status;
  assign version_o           = out_res.version;
  assign header_length_o     = out_res.header_length;
  assign packet_kind_o       = out_res.packet_kind;
  assign flag_bits_o         = out_res.flag_bits;
  assign hop_limit_o         = out_res.hop_limit;
  assign service_class_o     = out_res.service_class;
  assign source_node_o       = out_res.source_node;
  assign target_node_o       = out_res.target_node;
  assign connection_number_o = out_res.connection_number;
  assign sequence_number_o   = out_res.sequence_number;
  assign payload_length_o    = out_res.payload_length;

`ifndef SYNTHESIS
  // A finished header never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !pstat.result_fire)
    else $error("result overwritten while output stalled");

  // A finished header shows up at the output in the next cycle
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pstat.result_fire |=> out_valid_o)
    else $error("finished header did not reach the output register");

  // Back pressure only when the input register holds a word
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> pstat.s1_valid)
    else $error("input stalled with an empty input register");

  // A new output word only follows a completed header
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && !out_ready_i)) |-> $past(pstat.result_fire))
    else $error("output word without a completed header");
`endif

endmodule
